FILE: hdl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define F12_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define F12_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define F12_ASSERT(lbl, prop, msg)

`define F12_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

FILE: hdl/f12ccr_pkg.sv
`default_nettype none

package f12ccr_pkg;

  localparam int HANDLES      = 4;
  localparam int FAT_BYTES    = 8192;
  localparam int MAX_SEGMENTS = 64;

  localparam int HSEL_W    = (HANDLES > 1) ? $clog2(HANDLES) : 1;
  localparam int HNUM_W    = HSEL_W + 2;
  localparam int FA_W      = $clog2(FAT_BYTES);
  localparam int SEG_CNT_W = $clog2(MAX_SEGMENTS + 1);

  localparam int          MAX_CLUSTER_BYTES = 32768;
  localparam logic [11:0] CHAIN_END         = 12'hFFF;
  localparam logic [7:0]  NIB_HI_MASK       = 8'hF0;
  localparam logic [7:0]  NIB_LO_MASK       = 8'h0F;

  localparam logic [1:0] CFG_BPS = 2'd0;
  localparam logic [1:0] CFG_SPC = 2'd1;
  localparam logic [1:0] CFG_FDS = 2'd2;

  localparam logic [12:0] BPS_RESET = 13'd512;
  localparam logic [6:0]  SPC_RESET = 7'd1;
  localparam logic [15:0] FDS_RESET = 16'd33;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_OPEN    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_READ    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BASE,
    ST_TOP,
    ST_SEG_MUL,
    ST_SEG_ADD,
    ST_CH_RD0,
    ST_CH_RD1,
    ST_CH_EVAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [11:0] cluster;
    logic [15:0] offset;
    logic [15:0] remaining;
  } handle_rec_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  given_handle;
    logic        has_segment;
    logic [31:0] segment_address;
    logic [15:0] segment_bytes;
    logic [15:0] bytes_done;
    logic        last;
  } res_t;

  function automatic res_t make_res(input logic st, input logic [1:0] gh, input logic hs,
                                    input logic [31:0] addr, input logic [15:0] sb,
                                    input logic [15:0] done, input logic lst);
    res_t r;
    r.status          = st;
    r.given_handle    = gh;
    r.has_segment     = hs;
    r.segment_address = addr;
    r.segment_bytes   = sb;
    r.bytes_done      = done;
    r.last            = lst;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/f12ccr_ram.sv
`default_nettype none

module f12ccr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                                          clk,
  input  wire                                          en,
  input  wire                                          we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire  [WIDTH-1:0]                             wdata,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/fat12_cluster_chain_reader.sv
// channel   | handshake                | payload
// ----------+--------------------------+--------------------------------------------------
// command   | start, busy              | in_kind in_handle in_fat_byte_index in_fat_byte
//           |                          | in_first_cluster in_file_size in_request_bytes
// result    | out_valid (1-cycle pulse)| out_status out_given_handle out_has_segment
//           |                          | out_segment_address out_segment_bytes
//           |                          | out_bytes_done out_last
// config    | cfg_we                   | cfg_index cfg_data
//
// load, open and release leave busy low; the result is registered and appears the next cycle
// a read of an open handle holds busy through LOAD, BASE, then TOP with SEG_MUL and SEG_ADD per
//   segment or CH_RD0, CH_RD1 and CH_EVAL per FAT chain step (one FAT RAM port, two byte
//   reads per entry), then FINISH; the last busy cycle writes the handle back
// the FAT bytes and the handle records sit in single-port RAMs with a registered read
// rst_n is synchronous; it frees all handles and restores the config defaults, FAT content
//   is kept as is
// results cannot be stalled: each one is shown for exactly one cycle
`default_nettype none

`include "assert_macros.svh"

module fat12_cluster_chain_reader (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  in_kind,
  input  wire  [1:0]  in_handle,
  input  wire  [12:0] in_fat_byte_index,
  input  wire  [7:0]  in_fat_byte,
  input  wire  [11:0] in_first_cluster,
  input  wire  [15:0] in_file_size,
  input  wire  [15:0] in_request_bytes,
  output logic        out_valid,
  output logic        out_status,
  output logic [1:0]  out_given_handle,
  output logic        out_has_segment,
  output logic [31:0] out_segment_address,
  output logic [15:0] out_segment_bytes,
  output logic [15:0] out_bytes_done,
  output logic        out_last,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  localparam int          HSEL_W    = f12ccr_pkg::HSEL_W;
  localparam int          HNUM_W    = f12ccr_pkg::HNUM_W;
  localparam int          FA_W      = f12ccr_pkg::FA_W;
  localparam int          SEG_CNT_W = f12ccr_pkg::SEG_CNT_W;
  localparam logic [13:0] FAT_LIM   = 14'(f12ccr_pkg::FAT_BYTES);

  f12ccr_pkg::state_t      state_r, state_nxt;
  logic [12:0]             bps_r;
  logic [6:0]              spc_r;
  logic [15:0]             fds_r;
  logic [f12ccr_pkg::HANDLES-1:0] in_use_r, in_use_nxt;
  logic [HSEL_W-1:0]       h_r, h_nxt;
  logic [11:0]             cl_r, cl_nxt;
  logic [15:0]             off_r, off_nxt;
  logic [15:0]             rem_r, rem_nxt;
  logic [15:0]             size_r, size_nxt;
  logic [15:0]             done_r, done_nxt;
  logic [SEG_CNT_W-1:0]    n_r, n_nxt;
  logic [19:0]             prod_r, prod_nxt;
  logic [15:0]             bpc_r, bpc_nxt;
  logic [31:0]             base_r, base_nxt;
  logic [15:0]             take_r, take_nxt;
  logic [31:0]             cmul_r, cmul_nxt;
  logic [12:0]             at_r, at_nxt;
  logic [7:0]              lo_r, lo_nxt;
  logic                    pend_r, pend_nxt;
  logic [31:0]             pend_addr_r, pend_addr_nxt;
  logic [15:0]             pend_bytes_r, pend_bytes_nxt;
  logic [15:0]             pend_done_r, pend_done_nxt;
  logic                    out_valid_r, out_valid_nxt;
  f12ccr_pkg::res_t        out_r, out_nxt;

  logic                    accept;
  f12ccr_pkg::kind_t       kind;
  logic [HSEL_W-1:0]       hsel;
  logic                    h_ok;
  logic                    idx_ok;
  logic                    free_found;
  logic [HSEL_W-1:0]       free_idx;
  logic [HNUM_W-1:0]       free_num;
  logic [12:0]             at_calc;
  logic [12:0]             at_inc;
  logic                    hi_ok;
  logic [7:0]              hi_byte;
  logic [11:0]             next_cl;
  logic [16:0]             end_sum;
  logic [15:0]             off_sum;
  logic [12:0]             cl_m2;
  logic signed [29:0]      cprod;
  logic [31:0]             seg_addr;
  logic                    read_done;

  logic                    fat_en, fat_we;
  logic [FA_W-1:0]         fat_addr;
  logic [7:0]              fat_rdata;
  logic                    hr_en, hr_we;
  logic [HSEL_W-1:0]       hr_addr;
  f12ccr_pkg::handle_rec_t hr_wdata, hr_rdata;

  f12ccr_ram #(
    .WIDTH (8),
    .DEPTH (f12ccr_pkg::FAT_BYTES)
  ) u_fat_ram (
    .clk   (clk),
    .en    (fat_en),
    .we    (fat_we),
    .addr  (fat_addr),
    .wdata (in_fat_byte),
    .rdata (fat_rdata)
  );

  f12ccr_ram #(
    .WIDTH ($bits(f12ccr_pkg::handle_rec_t)),
    .DEPTH (f12ccr_pkg::HANDLES)
  ) u_handle_ram (
    .clk   (clk),
    .en    (hr_en),
    .we    (hr_we),
    .addr  (hr_addr),
    .wdata (hr_wdata),
    .rdata (hr_rdata)
  );

  assign busy     = (state_r != f12ccr_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign kind     = f12ccr_pkg::kind_t'(in_kind);
  assign hsel     = HSEL_W'(in_handle);
  assign h_ok     = HNUM_W'(in_handle) < HNUM_W'(f12ccr_pkg::HANDLES);
  assign idx_ok   = {1'b0, in_fat_byte_index} < FAT_LIM;
  assign free_num = HNUM_W'(free_idx);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = f12ccr_pkg::HANDLES - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = HSEL_W'(i);
      end
    end
  end

  // 12-bit entry c sits at byte (3*c)/2
  assign at_calc = 13'(cl_r) + 13'(cl_r[11:1]);
  assign at_inc  = at_r + 13'd1;
  assign hi_ok   = ({1'b0, at_r} + 14'd1) < FAT_LIM;
  assign hi_byte = hi_ok ? fat_rdata : 8'd0;
  assign next_cl = cl_r[0] ? {hi_byte, 4'((lo_r & f12ccr_pkg::NIB_HI_MASK) >> 4)}
                           : {4'(hi_byte & f12ccr_pkg::NIB_LO_MASK), lo_r};

  assign end_sum   = {1'b0, size_r} + {1'b0, off_r};
  assign off_sum   = off_r + take_r;
  assign cl_m2     = {1'b0, cl_r} - 13'd2;
  assign cprod     = $signed({1'b0, bpc_r}) * $signed(cl_m2);
  assign seg_addr  = base_r + cmul_r + 32'(off_r);
  assign read_done = (size_r == 16'd0) || (n_r == SEG_CNT_W'(f12ccr_pkg::MAX_SEGMENTS));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      f12ccr_pkg::ST_IDLE: begin
        if (accept && kind == f12ccr_pkg::KIND_READ && h_ok && in_use_r[hsel]) begin
          state_nxt = f12ccr_pkg::ST_LOAD;
        end
      end
      f12ccr_pkg::ST_LOAD:    state_nxt = f12ccr_pkg::ST_BASE;
      f12ccr_pkg::ST_BASE:    state_nxt = f12ccr_pkg::ST_TOP;
      f12ccr_pkg::ST_TOP: begin
        priority if (read_done) begin
          state_nxt = f12ccr_pkg::ST_FINISH;
        end else if (off_r >= bpc_r) begin
          state_nxt = f12ccr_pkg::ST_CH_RD0;
        end else begin
          state_nxt = f12ccr_pkg::ST_SEG_MUL;
        end
      end
      f12ccr_pkg::ST_SEG_MUL: state_nxt = f12ccr_pkg::ST_SEG_ADD;
      f12ccr_pkg::ST_SEG_ADD: begin
        state_nxt = (off_sum == bpc_r) ? f12ccr_pkg::ST_CH_RD0 : f12ccr_pkg::ST_TOP;
      end
      f12ccr_pkg::ST_CH_RD0:  state_nxt = f12ccr_pkg::ST_CH_RD1;
      f12ccr_pkg::ST_CH_RD1:  state_nxt = f12ccr_pkg::ST_CH_EVAL;
      f12ccr_pkg::ST_CH_EVAL: begin
        state_nxt = (next_cl == f12ccr_pkg::CHAIN_END) ? f12ccr_pkg::ST_FINISH
                                                       : f12ccr_pkg::ST_TOP;
      end
      f12ccr_pkg::ST_FINISH:  state_nxt = f12ccr_pkg::ST_IDLE;
      default:                state_nxt = f12ccr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_use_nxt     = in_use_r;
    h_nxt          = h_r;
    cl_nxt         = cl_r;
    off_nxt        = off_r;
    rem_nxt        = rem_r;
    size_nxt       = size_r;
    done_nxt       = done_r;
    n_nxt          = n_r;
    prod_nxt       = prod_r;
    bpc_nxt        = bpc_r;
    base_nxt       = base_r;
    take_nxt       = take_r;
    cmul_nxt       = cmul_r;
    at_nxt         = at_r;
    lo_nxt         = lo_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    pend_bytes_nxt = pend_bytes_r;
    pend_done_nxt  = pend_done_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    fat_en         = 1'b0;
    fat_we         = 1'b0;
    fat_addr       = FA_W'(in_fat_byte_index);
    hr_en          = 1'b0;
    hr_we          = 1'b0;
    hr_addr        = hsel;
    hr_wdata       = '{cluster: in_first_cluster, offset: 16'd0, remaining: in_file_size};

    unique case (state_r)
      f12ccr_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            f12ccr_pkg::KIND_LOAD: begin
              fat_en        = idx_ok;
              fat_we        = idx_ok;
              out_valid_nxt = 1'b1;
              out_nxt       = f12ccr_pkg::make_res(1'b0, 2'd0, 1'b0, 32'd0, 16'd0, 16'd0, 1'b1);
            end
            f12ccr_pkg::KIND_OPEN: begin
              out_valid_nxt = 1'b1;
              if (free_found) begin
                in_use_nxt[free_idx] = 1'b1;
                hr_en   = 1'b1;
                hr_we   = 1'b1;
                hr_addr = free_idx;
                out_nxt = f12ccr_pkg::make_res(1'b0, free_num[1:0], 1'b0, 32'd0, 16'd0, 16'd0,
                                               1'b1);
              end else begin
                out_nxt = f12ccr_pkg::make_res(1'b1, 2'd0, 1'b0, 32'd0, 16'd0, 16'd0, 1'b1);
              end
            end
            f12ccr_pkg::KIND_RELEASE: begin
              if (h_ok) begin
                in_use_nxt[hsel] = 1'b0;
              end
              out_valid_nxt = 1'b1;
              out_nxt       = f12ccr_pkg::make_res(1'b0, 2'd0, 1'b0, 32'd0, 16'd0, 16'd0, 1'b1);
            end
            f12ccr_pkg::KIND_READ: begin
              if (h_ok && in_use_r[hsel]) begin
                hr_en    = 1'b1;
                h_nxt    = hsel;
                size_nxt = in_request_bytes;
                done_nxt = 16'd0;
                n_nxt    = '0;
                pend_nxt = 1'b0;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt = f12ccr_pkg::make_res(1'b0, 2'd0, 1'b0, 32'd0, 16'd0, 16'd0, 1'b1);
              end
            end
          endcase
        end
      end
      f12ccr_pkg::ST_LOAD: begin
        cl_nxt   = hr_rdata.cluster;
        off_nxt  = hr_rdata.offset;
        rem_nxt  = hr_rdata.remaining;
        prod_nxt = 20'(spc_r * bps_r);
      end
      f12ccr_pkg::ST_BASE: begin
        priority if (prod_r == 20'd0) begin
          bpc_nxt = 16'd1;
        end else if (prod_r > 20'(f12ccr_pkg::MAX_CLUSTER_BYTES)) begin
          bpc_nxt = 16'(f12ccr_pkg::MAX_CLUSTER_BYTES);
        end else begin
          bpc_nxt = prod_r[15:0];
        end
        base_nxt = 32'(fds_r * bps_r);
        if (size_r > rem_r) begin
          size_nxt = rem_r;
        end
      end
      f12ccr_pkg::ST_TOP: begin
      end
      f12ccr_pkg::ST_SEG_MUL: begin
        take_nxt = (end_sum > {1'b0, bpc_r}) ? (bpc_r - off_r) : size_r;
        cmul_nxt = 32'(cprod);
      end
      f12ccr_pkg::ST_SEG_ADD: begin
        if (pend_r) begin
          out_valid_nxt = 1'b1;
          out_nxt = f12ccr_pkg::make_res(1'b0, 2'd0, 1'b1, pend_addr_r, pend_bytes_r,
                                         pend_done_r, 1'b0);
        end
        pend_nxt       = 1'b1;
        pend_addr_nxt  = seg_addr;
        pend_bytes_nxt = take_r;
        pend_done_nxt  = done_r + take_r;
        done_nxt       = done_r + take_r;
        size_nxt       = size_r - take_r;
        rem_nxt        = rem_r - take_r;
        off_nxt        = off_sum;
        n_nxt          = n_r + SEG_CNT_W'(1);
      end
      f12ccr_pkg::ST_CH_RD0: begin
        at_nxt   = at_calc;
        fat_en   = 1'b1;
        fat_addr = FA_W'(at_calc);
      end
      f12ccr_pkg::ST_CH_RD1: begin
        lo_nxt   = ({1'b0, at_r} < FAT_LIM) ? fat_rdata : 8'd0;
        fat_en   = 1'b1;
        fat_addr = FA_W'(at_inc);
      end
      f12ccr_pkg::ST_CH_EVAL: begin
        off_nxt = 16'd0;
        if (next_cl != f12ccr_pkg::CHAIN_END) begin
          cl_nxt = next_cl;
        end
      end
      f12ccr_pkg::ST_FINISH: begin
        hr_en         = 1'b1;
        hr_we         = 1'b1;
        hr_addr       = h_r;
        hr_wdata      = '{cluster: cl_r, offset: off_r, remaining: rem_r};
        out_valid_nxt = 1'b1;
        if (pend_r) begin
          out_nxt = f12ccr_pkg::make_res(1'b0, 2'd0, 1'b1, pend_addr_r, pend_bytes_r,
                                         pend_done_r, 1'b1);
        end else begin
          out_nxt = f12ccr_pkg::make_res(1'b0, 2'd0, 1'b0, 32'd0, 16'd0, 16'd0, 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= f12ccr_pkg::ST_IDLE;
      in_use_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      bps_r       <= f12ccr_pkg::BPS_RESET;
      spc_r       <= f12ccr_pkg::SPC_RESET;
      fds_r       <= f12ccr_pkg::FDS_RESET;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          f12ccr_pkg::CFG_BPS: bps_r <= cfg_data[12:0];
          f12ccr_pkg::CFG_SPC: spc_r <= cfg_data[6:0];
          f12ccr_pkg::CFG_FDS: fds_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r          <= h_nxt;
    cl_r         <= cl_nxt;
    off_r        <= off_nxt;
    rem_r        <= rem_nxt;
    size_r       <= size_nxt;
    done_r       <= done_nxt;
    n_r          <= n_nxt;
    prod_r       <= prod_nxt;
    bpc_r        <= bpc_nxt;
    base_r       <= base_nxt;
    take_r       <= take_nxt;
    cmul_r       <= cmul_nxt;
    at_r         <= at_nxt;
    lo_r         <= lo_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_bytes_r <= pend_bytes_nxt;
    pend_done_r  <= pend_done_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_given_handle    = out_r.given_handle;
  assign out_has_segment     = out_r.has_segment;
  assign out_segment_address = out_r.segment_address;
  assign out_segment_bytes   = out_r.segment_bytes;
  assign out_bytes_done      = out_r.bytes_done;
  assign out_last            = out_r.last;

  `F12_ASSERT(a_noseg_last, out_valid_r && !out_r.has_segment |-> out_r.last, "bare not last")
  `F12_ASSERT(a_seg_len, out_valid_r && out_r.has_segment |-> out_r.segment_bytes != 16'd0, "empty")
  `F12_ASSERT(a_seg_fits, state_r == f12ccr_pkg::ST_SEG_ADD |-> off_sum <= bpc_r, "past end")
  `F12_ASSERT(a_seg_count, busy |-> n_r <= SEG_CNT_W'(f12ccr_pkg::MAX_SEGMENTS), "seg overrun")
  `F12_ASSERT_NEXT(a_cmd_result, accept && kind != f12ccr_pkg::KIND_READ, out_valid_r && out_r.last, "no result")

endmodule

`default_nettype wire
